FILE: src/tart_pkg.sv
`default_nettype none

package tart_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned DELAY_W  = 20;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_ENABLE   = 3'd0,
        REG_COMPARE_MODE     = 3'd1,
        REG_LOW_THRESHOLD    = 3'd2,
        REG_HIGH_THRESHOLD   = 3'd3,
        REG_QUALIFY_MODE     = 3'd4,
        REG_RELAY_MODE       = 3'd5,
        REG_QUALIFY_DELAY_MS = 3'd6,
        REG_RELAY_DELAY_MS   = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        CMP_ABOVE   = 2'd0,
        CMP_BELOW   = 2'd1,
        CMP_INSIDE  = 2'd2,
        CMP_OUTSIDE = 2'd3
    } compare_mode_t;

    typedef enum logic {
        QUAL_LEVEL  = 1'b0,
        QUAL_STABLE = 1'b1
    } qualify_mode_t;

    // code 3 is unused and turns the relay off
    typedef enum logic [1:0] {
        RELAY_DIRECT    = 2'd0,
        RELAY_ON_DELAY  = 2'd1,
        RELAY_OFF_DELAY = 2'd2
    } relay_mode_t;

    typedef struct packed {
        logic                       channel_enable;
        compare_mode_t              compare_mode;
        logic signed [SAMPLE_W-1:0] low_threshold;
        logic signed [SAMPLE_W-1:0] high_threshold;
        qualify_mode_t              qualify_mode;
        relay_mode_t                relay_mode;
        logic [DELAY_W-1:0]         qualify_delay_ms;
        logic [DELAY_W-1:0]         relay_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] start_ms;
    } timer_t;

    typedef struct packed {
        logic relay_on;
        logic condition_met;
        logic trigger_qualified;
    } result_t;

endpackage

`default_nettype wire

FILE: src/threshold_alarm_relay_timer_core.sv
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  weight_sample, now_ms
// out       output     out_valid/out_ready relay_on, condition_met, trigger_qualified
// cfg       input      cfg_write          cfg_index, cfg_data
//
// one item per cycle sustained while out_ready is high; each item passes the input register, then the result register
// the path per item is one window compare and two elapsed-time subtract/compares
// reset clears the configuration, both timers and the valid flags
// a held result stalls the input register only; in_ready drops once both are full
`default_nettype none

module threshold_alarm_relay_timer_core
    import tart_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input item channel
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] weight_sample,
    input  wire logic [TIME_W-1:0]          now_ms,
    // result item channel
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            relay_on,
    output logic                            condition_met,
    output logic                            trigger_qualified,
    // configuration write port
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // input register: holds one accepted item until it is evaluated
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]          now_reg;

    // timer state of the qualification and relay stages
    timer_t qual_reg;
    timer_t qual_next;
    timer_t relay_tmr_reg;
    timer_t relay_tmr_next;

    // result register
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic advance;   // the input register item moves into the result register
    logic take_in;

    // the result slot is free when empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || !out_valid_reg || out_ready;
    assign take_in  = in_valid && in_ready;

    // configuration writes, masked to the register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_CHANNEL_ENABLE:   cfg_reg.channel_enable   <= cfg_data[0];
                REG_COMPARE_MODE:     cfg_reg.compare_mode     <= compare_mode_t'(cfg_data[1:0]);
                REG_LOW_THRESHOLD:    cfg_reg.low_threshold    <= cfg_data[SAMPLE_W-1:0];
                REG_HIGH_THRESHOLD:   cfg_reg.high_threshold   <= cfg_data[SAMPLE_W-1:0];
                REG_QUALIFY_MODE:     cfg_reg.qualify_mode     <= qualify_mode_t'(cfg_data[0]);
                REG_RELAY_MODE:       cfg_reg.relay_mode       <= relay_mode_t'(cfg_data[1:0]);
                REG_QUALIFY_DELAY_MS: cfg_reg.qualify_delay_ms <= cfg_data[DELAY_W-1:0];
                REG_RELAY_DELAY_MS:   cfg_reg.relay_delay_ms   <= cfg_data[DELAY_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            sample_reg <= weight_sample;
            now_reg    <= now_ms;
        end
    end

    // per-item evaluation: compare, qualify, relay timing
    tart_eval u_eval (
        .cfg        (cfg_reg),
        .sample     (sample_reg),
        .now        (now_reg),
        .qual_cur   (qual_reg),
        .relay_cur  (relay_tmr_reg),
        .qual_next  (qual_next),
        .relay_next (relay_tmr_next),
        .result     (result_next)
    );

    // timers only move when an item is actually evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qual_reg      <= '0;
            relay_tmr_reg <= '0;
        end
        else if (advance)
        begin
            qual_reg      <= qual_next;
            relay_tmr_reg <= relay_tmr_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign relay_on          = result_reg.relay_on;
    assign condition_met     = result_reg.condition_met;
    assign trigger_qualified = result_reg.trigger_qualified;

endmodule

`default_nettype wire

FILE: src/tart_eval.sv
`default_nettype none

module tart_eval
    import tart_pkg::*;
(
    input  wire cfg_t                       cfg,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic [TIME_W-1:0]          now,
    input  wire timer_t                     qual_cur,
    input  wire timer_t                     relay_cur,
    output timer_t                          qual_next,
    output timer_t                          relay_next,
    output result_t                         result
);

    logic              cond;
    logic              trig;
    logic              relay;
    logic [TIME_W-1:0] qual_elapsed;
    logic [TIME_W-1:0] relay_elapsed;
    logic [TIME_W-1:0] qual_delay;
    logic [TIME_W-1:0] relay_delay;

    assign qual_delay  = {{(TIME_W-DELAY_W){1'b0}}, cfg.qualify_delay_ms};
    assign relay_delay = {{(TIME_W-DELAY_W){1'b0}}, cfg.relay_delay_ms};

    // a timer that starts on this item has zero elapsed time
    assign qual_elapsed  = qual_cur.running  ? now - qual_cur.start_ms  : '0;
    assign relay_elapsed = relay_cur.running ? now - relay_cur.start_ms : '0;

    // compare
    always_comb
    begin
        cond = 1'b0;
        unique case (cfg.compare_mode)
            CMP_ABOVE:   cond = sample >= cfg.low_threshold;
            CMP_BELOW:   cond = sample <= cfg.low_threshold;
            CMP_INSIDE:  cond = (sample >= cfg.low_threshold) &&
                                (sample <= cfg.high_threshold);
            CMP_OUTSIDE: cond = (sample < cfg.low_threshold) ||
                                (sample > cfg.high_threshold);
            default:     cond = 1'b0;
        endcase
        if (!cfg.channel_enable)
        begin
            cond = 1'b0;
        end
    end

    // qualification
    always_comb
    begin
        qual_next = qual_cur;
        trig      = cond;
        if (cfg.qualify_mode == QUAL_STABLE)
        begin
            if (!cond)
            begin
                qual_next.running = 1'b0;
                trig              = 1'b0;
            end
            else
            begin
                if (!qual_cur.running)
                begin
                    qual_next.running  = 1'b1;
                    qual_next.start_ms = now;
                end
                trig = qual_elapsed >= qual_delay;
            end
        end
    end

    // relay timing
    always_comb
    begin
        relay_next = relay_cur;
        relay      = 1'b0;
        unique case (cfg.relay_mode)
            RELAY_DIRECT:
            begin
                relay = trig;
            end
            RELAY_ON_DELAY:
            begin
                if (!trig)
                begin
                    relay_next.running = 1'b0;
                end
                else
                begin
                    if (!relay_cur.running)
                    begin
                        relay_next.running  = 1'b1;
                        relay_next.start_ms = now;
                    end
                    relay = relay_elapsed >= relay_delay;
                end
            end
            RELAY_OFF_DELAY:
            begin
                if (trig)
                begin
                    relay_next.running = 1'b0;
                    relay              = 1'b1;
                end
                else
                begin
                    if (!relay_cur.running)
                    begin
                        relay_next.running  = 1'b1;
                        relay_next.start_ms = now;
                    end
                    relay = relay_elapsed < relay_delay;
                end
            end
            default:
            begin
                relay = 1'b0;
            end
        endcase
    end

    assign result.relay_on          = relay;
    assign result.condition_met     = cond;
    assign result.trigger_qualified = trig;

endmodule

`default_nettype wire

FILE: src/tart_checker.sv
`default_nettype none

module tart_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic relay_on,
    input wire logic condition_met,
    input wire logic trigger_qualified
);

    // qualification can only narrow the raw compare result
    a_qual_implies_cond: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trigger_qualified |-> condition_met)
        else $error("qualified item without a met condition");

    // the input side only stalls behind a held result
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // an accepted item into an empty block shows a result after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result missing after accepted item");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(relay_on) &&
        $stable(condition_met) && $stable(trigger_qualified))
        else $error("held result changed");

endmodule

bind threshold_alarm_relay_timer_core tart_checker u_tart_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .relay_on          (relay_on),
    .condition_met     (condition_met),
    .trigger_qualified (trigger_qualified)
);

`default_nettype wire
